// ===== rtl/core/dspe_pkg.sv =====
// shared types and constants for the diagnostic serial poll engine
`default_nettype none
package dspe_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_BYTE  = 3'd1;
    localparam logic [2:0] OP_QUERY = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RETRIES   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT   = 2'd2;
    localparam logic [1:0] ST_NO_ECHO   = 2'd3;

    localparam logic [7:0] CODE_ENGINE = 8'h78;
    localparam logic [7:0] CODE_TRANS  = 8'h45;
    localparam logic [7:0] CODE_STEER  = 8'h92;
    localparam logic [7:0] CODE_RESET  = 8'h12;
    localparam logic [7:0] CODE_WRITE  = 8'hAA;

    localparam logic [0:0] REG_MAX_WAIT    = 1'b0;
    localparam logic [0:0] REG_MAX_RETRIES = 1'b1;

    localparam logic [15:0] DUMMY_ADDR = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_SOLO  = 4'd1,
        PH_RST_PRE   = 4'd2,
        PH_RST_RETRY = 4'd3,
        PH_Q_DUMMY   = 4'd4,
        PH_Q_WAIT    = 4'd5,
        PH_CAPTURE   = 4'd6,
        PH_WRITE     = 4'd7
    } phase_t;

    // all results caused by one input: an optional 4-byte frame and an optional tail
    typedef struct packed {
        logic             has_frame;
        logic [3:0][7:0]  frame;
        logic             has_tail;
        logic [1:0]       tail_kind;
        logic [7:0]       tail_val;
        logic [15:0]      tail_idx;
    } bundle_t;

endpackage
`default_nettype wire

// ===== rtl/core/dspe_front.sv =====
// front end: protocol state machine, turns each input into a result bundle
`default_nettype none
module dspe_front
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire  [0:0]            cfg_index,
    input  wire  [7:0]            cfg_data,
    input  wire                   take,
    input  wire  [2:0]            opcode,
    input  wire  [7:0]            rx_byte,
    input  wire  [1:0]            unit,
    input  wire  [15:0]           address,
    input  wire  [15:0]           sample_count,
    input  wire  [7:0]            write_data,
    output dspe_pkg::bundle_t     bundle,
    output logic                  bundle_valid
);
    import dspe_pkg::*;

    logic [7:0]  max_wait_reg, max_retries_reg;
    logic [7:0]  fb0_reg, fb1_reg, fb0_next, fb1_next;
    logic [1:0]  frame_pos_reg, frame_pos_next;
    logic [15:0] seen_addr_reg, seen_addr_next;
    logic [7:0]  seen_val_reg, seen_val_next;
    logic        heard_reg, heard_next;
    logic [7:0]  prev_cmd_reg, prev_cmd_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] wanted_reg, wanted_next;
    logic [15:0] captured_reg, captured_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  retry_reg, retry_next;
    logic [7:0]  wait_reg, wait_next;
    logic [7:0]  pending_reg, pending_next;
    logic [7:0]  rst_retry_reg, rst_retry_next;

    logic [7:0]  mw, w_inc, code;
    logic [1:0]  fpos;
    logic [15:0] qa;
    logic        do_q, q_dummy, do_rst, do_cap, do_fin;
    phase_t      rst_ph;
    logic [1:0]  fin_st;

    assign mw    = (max_wait_reg == 8'd0) ? 8'd1 : max_wait_reg;
    assign w_inc = wait_reg + 8'd1;

    always_comb
    begin
        fb0_next       = fb0_reg;
        fb1_next       = fb1_reg;
        frame_pos_next = frame_pos_reg;
        seen_addr_next = seen_addr_reg;
        seen_val_next  = seen_val_reg;
        heard_next     = heard_reg;
        prev_cmd_next  = prev_cmd_reg;
        target_next    = target_reg;
        wanted_next    = wanted_reg;
        captured_next  = captured_reg;
        phase_next     = phase_reg;
        retry_next     = retry_reg;
        wait_next      = wait_reg;
        pending_next   = pending_reg;
        rst_retry_next = rst_retry_reg;
        bundle         = '0;
        do_q           = 1'b0;
        q_dummy        = 1'b0;
        do_rst         = 1'b0;
        rst_ph         = PH_RST_SOLO;
        do_cap         = 1'b0;
        do_fin         = 1'b0;
        fin_st         = ST_OK;
        fpos           = 2'd0;
        code           = CODE_ENGINE;
        qa             = 16'd0;

        if (opcode == OP_TICK)
        begin
            case (phase_reg)
                PH_RST_SOLO, PH_RST_PRE, PH_RST_RETRY:
                begin
                    if (!heard_reg || (wait_reg >= max_wait_reg &&
                                       rst_retry_reg >= max_retries_reg))
                    begin
                        // reset finished, well or not
                        if (!heard_reg)
                            frame_pos_next = 2'd0;
                        if (phase_reg == PH_RST_SOLO)
                        begin
                            do_fin = 1'b1;
                            fin_st = heard_reg ? ST_RETRIES : ST_OK;
                        end
                        else
                        begin
                            do_q    = 1'b1;
                            q_dummy = (phase_reg == PH_RST_PRE) && (prev_cmd_reg == CODE_STEER);
                        end
                    end
                    else if (wait_reg < max_wait_reg)
                    begin
                        wait_next  = w_inc;
                        heard_next = 1'b0;
                    end
                    else
                    begin
                        rst_retry_next = rst_retry_reg + 8'd1;
                        bundle.has_frame = 1'b1;
                        bundle.frame     = {8'd0, 8'd0, 8'd0, CODE_RESET};
                        heard_next       = 1'b0;
                        wait_next        = 8'd0;
                    end
                end
                PH_Q_DUMMY:
                begin
                    wait_next = w_inc;
                    if (seen_addr_reg == DUMMY_ADDR || w_inc >= mw)
                        do_q = 1'b1;
                end
                PH_Q_WAIT:
                begin
                    wait_next = w_inc;
                    if (seen_addr_reg == target_reg)
                        do_cap = 1'b1;
                    else if (w_inc >= mw)
                    begin
                        if (retry_reg < max_retries_reg)
                        begin
                            retry_next = retry_reg + 8'd1;
                            if (prev_cmd_reg == CODE_STEER)
                                do_q = 1'b1;
                            else
                            begin
                                do_rst = 1'b1;
                                rst_ph = PH_RST_RETRY;
                            end
                        end
                        else
                        begin
                            do_fin = 1'b1;
                            fin_st = ST_RETRIES;
                        end
                    end
                end
                PH_CAPTURE:
                begin
                    if (heard_reg)
                    begin
                        wait_next  = 8'd0;
                        heard_next = 1'b0;
                    end
                    else
                        wait_next = w_inc;
                    if (captured_reg >= wanted_reg)
                        do_fin = 1'b1;
                    else if (!heard_reg && w_inc >= mw)
                    begin
                        do_fin = 1'b1;
                        fin_st = ST_TIMEOUT;
                    end
                end
                PH_WRITE:
                begin
                    wait_next = w_inc;
                    if (seen_val_reg == pending_reg)
                        do_fin = 1'b1;
                    else if (w_inc >= mw)
                    begin
                        do_fin = 1'b1;
                        fin_st = ST_NO_ECHO;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (opcode == OP_BYTE)
        begin
            fpos       = (frame_pos_reg > 2'd2) ? 2'd0 : frame_pos_reg;
            heard_next = 1'b1;
            if (fpos == 2'd0)
                fb0_next = rx_byte;
            if (fpos == 2'd1)
                fb1_next = rx_byte;
            if (fpos != 2'd2)
                frame_pos_next = fpos + 2'd1;
            else
            begin
                frame_pos_next = 2'd0;
                seen_addr_next = {fb0_reg, fb1_reg};
                seen_val_next  = rx_byte;
                if ((phase_reg == PH_RST_PRE || phase_reg == PH_RST_RETRY ||
                     phase_reg == PH_Q_WAIT || phase_reg == PH_CAPTURE) &&
                    {fb0_reg, fb1_reg} == target_reg && captured_reg < wanted_reg)
                begin
                    bundle.has_tail  = 1'b1;
                    bundle.tail_kind = KIND_SAMPLE;
                    bundle.tail_val  = rx_byte;
                    bundle.tail_idx  = captured_reg;
                    captured_next    = captured_reg + 16'd1;
                end
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            if (opcode == OP_QUERY && unit != 2'd3)
            begin
                case (unit)
                    2'd0:    code = CODE_ENGINE;
                    2'd1:    code = CODE_TRANS;
                    default: code = CODE_STEER;
                endcase
                prev_cmd_next = code;
                target_next   = address;
                wanted_next   = sample_count;
                captured_next = 16'd0;
                retry_next    = 8'd0;
                if (prev_cmd_reg != code)
                begin
                    do_rst = 1'b1;
                    rst_ph = PH_RST_PRE;
                end
                else
                    do_q = 1'b1;
            end
            else if (opcode == OP_WRITE)
            begin
                pending_next     = write_data;
                bundle.has_frame = 1'b1;
                bundle.frame     = {write_data, address[7:0], address[15:8], CODE_WRITE};
                wait_next        = 8'd0;
                phase_next       = PH_WRITE;
                if (seen_val_reg == write_data)
                    do_fin = 1'b1;
            end
            else if (opcode == OP_RESET)
            begin
                do_rst = 1'b1;
                rst_ph = PH_RST_SOLO;
            end
        end

        if (do_rst)
        begin
            rst_retry_next   = 8'd0;
            phase_next       = rst_ph;
            bundle.has_frame = 1'b1;
            bundle.frame     = {8'd0, 8'd0, 8'd0, CODE_RESET};
            heard_next       = 1'b0;
            wait_next        = 8'd0;
        end
        if (do_q)
        begin
            qa               = q_dummy ? DUMMY_ADDR : target_next;
            bundle.has_frame = 1'b1;
            bundle.frame     = {8'd0, qa[7:0], qa[15:8], prev_cmd_next};
            wait_next        = 8'd0;
            phase_next       = q_dummy ? PH_Q_DUMMY : PH_Q_WAIT;
            if (!q_dummy && seen_addr_reg == target_next)
                do_cap = 1'b1;
        end
        if (do_cap)
        begin
            heard_next = 1'b0;
            wait_next  = 8'd0;
            phase_next = PH_CAPTURE;
            if (captured_next >= wanted_next)
                do_fin = 1'b1;
        end
        if (do_fin)
        begin
            bundle.has_tail  = 1'b1;
            bundle.tail_kind = KIND_STATUS;
            bundle.tail_val  = {6'd0, fin_st};
            phase_next       = PH_IDLE;
        end
    end

    assign bundle_valid = take && (bundle.has_frame || bundle.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wait_reg    <= 8'd10;
            max_retries_reg <= 8'd10;
            frame_pos_reg   <= 2'd0;
            seen_addr_reg   <= 16'd0;
            seen_val_reg    <= 8'd0;
            heard_reg       <= 1'b0;
            prev_cmd_reg    <= 8'd0;
            target_reg      <= 16'd0;
            wanted_reg      <= 16'd0;
            captured_reg    <= 16'd0;
            phase_reg       <= PH_IDLE;
            retry_reg       <= 8'd0;
            wait_reg        <= 8'd0;
            pending_reg     <= 8'd0;
            rst_retry_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MAX_WAIT)
                max_wait_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_MAX_RETRIES)
                max_retries_reg <= cfg_data;
            if (take)
            begin
                frame_pos_reg <= frame_pos_next;
                seen_addr_reg <= seen_addr_next;
                seen_val_reg  <= seen_val_next;
                heard_reg     <= heard_next;
                prev_cmd_reg  <= prev_cmd_next;
                target_reg    <= target_next;
                wanted_reg    <= wanted_next;
                captured_reg  <= captured_next;
                phase_reg     <= phase_next;
                retry_reg     <= retry_next;
                wait_reg      <= wait_next;
                pending_reg   <= pending_next;
                rst_retry_reg <= rst_retry_next;
            end
        end
    end

    // received frame bytes, meaningful only once written
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fb0_reg <= fb0_next;
            fb1_reg <= fb1_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dspe_queue.sv =====
// small bundle queue between front end and back end
`default_nettype none
module dspe_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  dspe_pkg::bundle_t     push_data,
    input  wire                   pop,
    output dspe_pkg::bundle_t     head,
    output logic                  not_empty,
    output logic                  full
);
    import dspe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dspe_back.sv =====
// back end: walks a bundle and drives one result per transaction
`default_nettype none
module dspe_back
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  dspe_pkg::bundle_t     head,
    input  wire                   head_valid,
    output logic                  pop,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            tx_byte,
    output logic [7:0]            sample,
    output logic [15:0]           sample_index,
    output logic [1:0]            status,
    output logic                  last
);
    import dspe_pkg::*;

    bundle_t      cur_reg;
    logic         busy_reg;
    logic [2:0]   pos_reg, pos_next;
    logic         load, is_tail, done;
    logic [1:0]   kind_next;
    logic [7:0]   tx_next, sample_next;
    logic [15:0]  idx_next;
    logic [1:0]   status_next;

    assign load = busy_reg && (!out_valid || !out_stall);
    assign pop  = !busy_reg && head_valid;

    always_comb
    begin
        is_tail     = (pos_reg == 3'd4);
        kind_next   = is_tail ? cur_reg.tail_kind : KIND_TX;
        tx_next     = is_tail ? 8'd0 : cur_reg.frame[pos_reg[1:0]];
        sample_next = (is_tail && cur_reg.tail_kind == KIND_SAMPLE) ? cur_reg.tail_val : 8'd0;
        idx_next    = (is_tail && cur_reg.tail_kind == KIND_SAMPLE) ? cur_reg.tail_idx : 16'd0;
        status_next = (is_tail && cur_reg.tail_kind == KIND_STATUS) ? cur_reg.tail_val[1:0]
                                                                   : ST_OK;
        done        = is_tail || (pos_reg == 3'd3 && !cur_reg.has_tail);
        pos_next    = pos_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (load)
        begin
            kind         <= kind_next;
            tx_byte      <= tx_next;
            sample       <= sample_next;
            sample_index <= idx_next;
            status       <= status_next;
            last         <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pos_reg   <= 3'd0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= head.has_frame ? 3'd0 : 3'd4;
            end
            else if (load)
            begin
                busy_reg <= !done;
                pos_reg  <= pos_next;
            end
            if (load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/diag_serial_poll_engine_core.sv =====
// top level of the diagnostic serial poll engine
//
//  channel   direction  handshake            payload
//  in        to core    in_valid / in_stall  opcode rx_byte unit address sample_count write_data
//  out       from core  out_valid/out_stall  kind tx_byte sample sample_index status last
//  cfg       to core    cfg_we               cfg_index cfg_data
//
// the front end takes one input transaction per cycle while the queue has room and
// updates the protocol state at once; each input yields up to five results
// the back end sends one result per cycle while out_stall is low, so a command frame with
// status drains as five results; it pops the next bundle only after the last result of the current one
// in_stall rises only when the bundle queue is full; out_stall holds the output register
// reset is asynchronous active low and returns the protocol to idle with default waits
`default_nettype none
module diag_serial_poll_engine_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           cfg_we,
    input  wire  [0:0]    cfg_index,
    input  wire  [7:0]    cfg_data,
    input  wire           in_valid,
    output logic          in_stall,
    input  wire  [2:0]    opcode,
    input  wire  [7:0]    rx_byte,
    input  wire  [1:0]    unit,
    input  wire  [15:0]   address,
    input  wire  [15:0]   sample_count,
    input  wire  [7:0]    write_data,
    output logic          out_valid,
    input  wire           out_stall,
    output logic [1:0]    kind,
    output logic [7:0]    tx_byte,
    output logic [7:0]    sample,
    output logic [15:0]   sample_index,
    output logic [1:0]    status,
    output logic          last
);
    import dspe_pkg::*;

    bundle_t  fr_bundle, q_head;
    logic     fr_valid, q_full, q_not_empty, q_pop, take;

    // an input transaction completes whenever the queue can take its bundle
    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    dspe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .unit         (unit),
        .address      (address),
        .sample_count (sample_count),
        .write_data   (write_data),
        .bundle       (fr_bundle),
        .bundle_valid (fr_valid)
    );

    // bundles with no results never enter the queue
    dspe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .push_data (fr_bundle),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    dspe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_not_empty),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .sample       (sample),
        .sample_index (sample_index),
        .status       (status),
        .last         (last)
    );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for diag_serial_poll_engine_core
//
// a table of directed transactions runs first, then random protocol traffic
// in several waiting/retry settings; every input transaction is run through
// an in-bench model of the poll engine and each output transaction is
// compared with the oldest owed result
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dspe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  rx;
        logic [1:0]  unit;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [7:0]  wdata;
    } item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [7:0]  smp;
        logic [15:0] idx;
        logic [1:0]  st;
        logic        last;
    } result_t;

    // directed row: the transaction, how many results it owes and the first
    // transmit byte (or zero), or n_res < 0 when only the model decides
    typedef struct {
        item_t      it;
        int         n_res;
        logic [7:0] first_tx;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_MAX_WAIT;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = OP_TICK;
    logic [7:0]  rx_byte = 8'd0;
    logic [1:0]  unit = 2'd0;
    logic [15:0] address = 16'd0;
    logic [15:0] sample_count = 16'd0;
    logic [7:0]  write_data = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  sample;
    logic [15:0] sample_index;
    logic [1:0]  status;
    logic        last;

    diag_serial_poll_engine_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .rx_byte      (rx_byte),
        .unit         (unit),
        .address      (address),
        .sample_count (sample_count),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .tx_byte      (tx_byte),
        .sample       (sample),
        .sample_index (sample_index),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // poll engine model: its own copy of the protocol state
    // ---------------------------------------------------------------
    logic [7:0]  wait_limit = 8'd10;
    logic [7:0]  retry_limit = 8'd10;
    logic [7:0]  rx_frame [3];
    logic [1:0]  rx_pos;
    logic [15:0] last_addr;
    logic [7:0]  last_val;
    bit          traffic;
    logic [7:0]  unit_cmd;
    logic [15:0] query_addr;
    logic [15:0] samples_wanted;
    logic [15:0] samples_taken;
    phase_t      eng_phase;
    logic [7:0]  query_retries;
    logic [7:0]  tick_count;
    logic [7:0]  write_value;
    logic [7:0]  reset_resends;

    result_t step_results[$];
    result_t owed[$];

    int errors = 0;
    int checked = 0;
    int n_samples = 0;
    int n_status = 0;
    int n_items = 0;
    bit hold_req = 1'b0;

    function automatic logic [7:0] wait_floor();
        return (wait_limit == 8'd0) ? 8'd1 : wait_limit;
    endfunction

    function automatic void emit(logic [1:0] k, logic [7:0] t, logic [7:0] s,
                                 logic [15:0] i, logic [1:0] st);
        result_t r;
        if (step_results.size() >= 5)
            return;
        r.kind = k; r.tx = t; r.smp = s; r.idx = i; r.st = st; r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void emit_frame(logic [7:0] a, logic [7:0] b,
                                       logic [7:0] c, logic [7:0] d);
        emit(KIND_TX, a, 8'd0, 16'd0, ST_OK);
        emit(KIND_TX, b, 8'd0, 16'd0, ST_OK);
        emit(KIND_TX, c, 8'd0, 16'd0, ST_OK);
        emit(KIND_TX, d, 8'd0, 16'd0, ST_OK);
    endfunction

    function automatic void conclude(logic [1:0] st);
        emit(KIND_STATUS, 8'd0, 8'd0, 16'd0, st);
        eng_phase = PH_IDLE;
    endfunction

    function automatic void send_reset_frame();
        emit_frame(CODE_RESET, 8'd0, 8'd0, 8'd0);
        traffic = 1'b0;
        tick_count = 8'd0;
    endfunction

    function automatic void begin_reset(phase_t p);
        reset_resends = 8'd0;
        eng_phase = p;
        send_reset_frame();
    endfunction

    function automatic void enter_capture();
        traffic = 1'b0;
        tick_count = 8'd0;
        eng_phase = PH_CAPTURE;
        if (samples_taken >= samples_wanted)
            conclude(ST_OK);
    endfunction

    function automatic void issue_query(bit dummy);
        logic [15:0] a;
        a = dummy ? DUMMY_ADDR : query_addr;
        emit_frame(unit_cmd, a[15:8], a[7:0], 8'd0);
        tick_count = 8'd0;
        eng_phase = dummy ? PH_Q_DUMMY : PH_Q_WAIT;
        if (!dummy && last_addr == query_addr)
            enter_capture();
    endfunction

    function automatic void query_mismatch();
        if (query_retries < retry_limit)
        begin
            query_retries++;
            if (unit_cmd == CODE_STEER)
                issue_query(1'b0);
            else
                begin_reset(PH_RST_RETRY);
        end
        else
            conclude(ST_RETRIES);
    endfunction

    function automatic void reset_done(bit ok);
        if (ok)
            rx_pos = 2'd0;
        if (eng_phase == PH_RST_SOLO)
            conclude(ok ? ST_OK : ST_RETRIES);
        else if (eng_phase == PH_RST_PRE)
            issue_query(unit_cmd == CODE_STEER);
        else
            issue_query(1'b0);
    endfunction

    function automatic void on_tick();
        case (eng_phase)
            PH_RST_SOLO, PH_RST_PRE, PH_RST_RETRY:
            begin
                if (!traffic)
                    reset_done(1'b1);
                else if (tick_count < wait_limit)
                begin
                    tick_count++;
                    traffic = 1'b0;
                end
                else if (reset_resends < retry_limit)
                begin
                    reset_resends++;
                    send_reset_frame();
                end
                else
                    reset_done(1'b0);
            end
            PH_Q_DUMMY:
            begin
                tick_count++;
                if (last_addr == DUMMY_ADDR || tick_count >= wait_floor())
                    issue_query(1'b0);
            end
            PH_Q_WAIT:
            begin
                tick_count++;
                if (last_addr == query_addr)
                    enter_capture();
                else if (tick_count >= wait_floor())
                    query_mismatch();
            end
            PH_CAPTURE:
            begin
                if (traffic)
                begin
                    tick_count = 8'd0;
                    traffic = 1'b0;
                end
                else
                    tick_count++;
                if (samples_taken >= samples_wanted)
                    conclude(ST_OK);
                else if (tick_count >= wait_floor())
                    conclude(ST_TIMEOUT);
            end
            PH_WRITE:
            begin
                tick_count++;
                if (last_val == write_value)
                    conclude(ST_OK);
                else if (tick_count >= wait_floor())
                    conclude(ST_NO_ECHO);
            end
            default: ;
        endcase
    endfunction

    function automatic void on_byte(logic [7:0] b);
        if (rx_pos > 2'd2)
            rx_pos = 2'd0;
        rx_frame[rx_pos] = b;
        rx_pos++;
        traffic = 1'b1;
        if (rx_pos < 2'd3)
            return;
        rx_pos = 2'd0;
        last_addr = {rx_frame[0], rx_frame[1]};
        last_val = rx_frame[2];
        if ((eng_phase == PH_RST_PRE || eng_phase == PH_RST_RETRY ||
             eng_phase == PH_Q_WAIT || eng_phase == PH_CAPTURE) &&
            last_addr == query_addr && samples_taken < samples_wanted)
        begin
            emit(KIND_SAMPLE, 8'd0, last_val, samples_taken, ST_OK);
            samples_taken++;
        end
    endfunction

    function automatic logic [7:0] code_of_unit(logic [1:0] u);
        case (u)
            2'd0: return CODE_ENGINE;
            2'd1: return CODE_TRANS;
            default: return CODE_STEER;
        endcase
    endfunction

    // runs one input transaction through the model, queues what it owes
    function automatic int poll_engine_step(item_t it);
        bit need;
        step_results.delete();
        if (it.op == OP_TICK)
            on_tick();
        else if (it.op == OP_BYTE)
            on_byte(it.rx);
        else if (eng_phase == PH_IDLE)
        begin
            if (it.op == OP_QUERY && it.unit < 2'd3)
            begin
                need = (unit_cmd != code_of_unit(it.unit));
                unit_cmd = code_of_unit(it.unit);
                query_addr = it.addr;
                samples_wanted = it.cnt;
                samples_taken = 16'd0;
                query_retries = 8'd0;
                if (need)
                    begin_reset(PH_RST_PRE);
                else
                    issue_query(1'b0);
            end
            else if (it.op == OP_WRITE)
            begin
                write_value = it.wdata;
                emit_frame(CODE_WRITE, it.addr[15:8], it.addr[7:0], write_value);
                tick_count = 8'd0;
                eng_phase = PH_WRITE;
                if (last_val == write_value)
                    conclude(ST_OK);
            end
            else if (it.op == OP_RESET)
                begin_reset(PH_RST_SOLO);
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            owed.push_back(step_results[i]);
        return step_results.size();
    endfunction

    // ---------------------------------------------------------------
    // mismatch reporting and output checking
    // ---------------------------------------------------------------
    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // stall and valid seen at the falling edge hold through the next rising edge
    always @(negedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            checked++;
            if (owed.size() == 0)
                report($sformatf("unowed result kind %0d tx %h smp %h idx %0d st %0d",
                                 kind, tx_byte, sample, sample_index, status));
            else
            begin
                e = owed.pop_front();
                if (kind !== e.kind || tx_byte !== e.tx || sample !== e.smp ||
                    sample_index !== e.idx || status !== e.st || last !== e.last)
                    report($sformatf("got k%0d tx%h s%h i%0d st%0d l%0d, want k%0d tx%h s%h i%0d st%0d l%0d",
                                     kind, tx_byte, sample, sample_index, status, last,
                                     e.kind, e.tx, e.smp, e.idx, e.st, e.last));
                if (e.kind == KIND_SAMPLE)
                    n_samples++;
                if (e.kind == KIND_STATUS)
                    n_status++;
            end
        end
    end

    // hard stop on a hung run
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14));
    endfunction

    // ---------------------------------------------------------------
    // result receiver: random stalls, one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int w;
        bit v;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                w = 250;
                hold_req = 1'b0;
            end
            else
                w = draw_gap();
            out_stall <= (w > 0);
            if (w > 0)
            begin
                repeat (w) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
            begin
                @(negedge clk);
                v = out_valid;
                @(posedge clk);
            end
            while (!v);
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------
    // offers one transaction after a random gap; returns at the accepting edge
    task automatic offer(input item_t it, output int n_res);
        int gap;
        bit s;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode <= it.op;
        rx_byte <= it.rx;
        unit <= it.unit;
        address <= it.addr;
        sample_count <= it.cnt;
        write_data <= it.wdata;
        in_valid <= 1'b1;
        n_res = poll_engine_step(it);
        do
        begin
            @(negedge clk);
            s = in_stall;
            @(posedge clk);
        end
        while (s);
    endtask

    // lets every owed result arrive, then holds the inputs idle before returning
    task automatic drain();
        in_valid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_WAIT)
            wait_limit = val;
        else
            retry_limit = val;
        @(posedge clk);
    endtask

    function automatic item_t noise_item();
        item_t it;
        it.op = 3'($urandom_range(0, 7));
        it.rx = 8'($urandom);
        it.unit = 2'($urandom_range(0, 3));
        it.addr = 16'($urandom);
        it.cnt = 16'($urandom);
        it.wdata = 8'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return query_addr;
        if (r < 8)
            return DUMMY_ADDR;
        return 16'($urandom);
    endfunction

    // next burst of transactions, shaped by where the engine stands
    function automatic void plan_burst(ref item_t burst[$]);
        item_t it;
        int r;
        logic [15:0] a;
        logic [7:0] v;
        it = noise_item();
        r = $urandom_range(0, 99);
        if (eng_phase == PH_IDLE)
        begin
            if (r < 45)
            begin
                it.op = OP_QUERY;
                it.unit = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                it.addr = pick_addr();
                r = $urandom_range(0, 19);
                it.cnt = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) :
                         16'($urandom_range(1, 4));
            end
            else if (r < 65)
            begin
                it.op = OP_WRITE;
                if ($urandom_range(0, 1))
                    it.wdata = last_val;
            end
            else if (r < 80)
                it.op = OP_RESET;
            else if (r < 90)
                it.op = OP_TICK;
            else if (r < 95)
                it.op = OP_BYTE;
            burst.push_back(it);
        end
        else if (r < 35)
        begin
            it.op = OP_TICK;
            burst.push_back(it);
        end
        else if (r < 80)
        begin
            // one well-formed address/value frame from the unit
            a = pick_addr();
            v = (eng_phase == PH_WRITE && $urandom_range(0, 1)) ? write_value : 8'($urandom);
            it.op = OP_BYTE;
            it.rx = a[15:8];
            burst.push_back(it);
            it = noise_item();
            it.op = OP_BYTE;
            it.rx = a[7:0];
            burst.push_back(it);
            it = noise_item();
            it.op = OP_BYTE;
            it.rx = v;
            burst.push_back(it);
        end
        else
        begin
            if (r < 90)
                it.op = OP_BYTE;
            else if (r < 95)
                it.op = 3'($urandom_range(2, 4));
            burst.push_back(it);
        end
    endfunction

    function automatic item_t mk(logic [2:0] op, logic [7:0] rx, logic [1:0] u,
                                 logic [15:0] a, logic [15:0] c, logic [7:0] d);
        item_t it;
        it.op = op; it.rx = rx; it.unit = u; it.addr = a; it.cnt = c; it.wdata = d;
        return it;
    endfunction

    row_t rows[$];
    int   phase_wait[5]  = '{3, 1, 255, 2, 5};
    int   phase_retry[5] = '{2, 0, 255, 1, 3};
    int   phase_items[5] = '{110, 75, 35, 95, 75};

    initial
    begin
        int n;
        item_t it;
        item_t burst[$];

        // reset state of the model
        rx_pos = 2'd0; last_addr = 16'd0; last_val = 8'd0; traffic = 1'b0;
        unit_cmd = 8'd0; query_addr = 16'd0; samples_wanted = 16'd0;
        samples_taken = 16'd0; eng_phase = PH_IDLE; query_retries = 8'd0;
        tick_count = 8'd0; write_value = 8'd0; reset_resends = 8'd0;
        foreach (rx_frame[i])
            rx_frame[i] = 8'd0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the default waits and retries
        rows = '{
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 0, 8'h00},   // idle tick
            '{mk(OP_RESET, 8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 4, CODE_RESET},
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 1, 8'h00},   // quiet: ok
            '{mk(OP_WRITE, 8'h00, 2'd0, 16'hFFFF, 16'd1, 8'h00), 5, CODE_WRITE}, // echoed
            '{mk(OP_WRITE, 8'h00, 2'd0, 16'h0000, 16'd1, 8'hFF), 4, CODE_WRITE},
            '{mk(OP_BYTE,  8'hFF, 2'd0, 16'h0000, 16'd1, 8'h00), 0, 8'h00},
            '{mk(OP_BYTE,  8'hFF, 2'd0, 16'h0000, 16'd1, 8'h00), 0, 8'h00},
            '{mk(OP_BYTE,  8'hFF, 2'd0, 16'h0000, 16'd1, 8'h00), 0, 8'h00},
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 1, 8'h00},   // write seen
            // steering query: reset first, then the dummy query
            '{mk(OP_QUERY, 8'h00, 2'd2, 16'h1234, 16'd2, 8'h00), 4, CODE_RESET},
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 4, CODE_STEER},
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 4, CODE_STEER},
            '{mk(OP_BYTE,  8'h12, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_BYTE,  8'h34, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_BYTE,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_BYTE,  8'h12, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_BYTE,  8'h34, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_BYTE,  8'hA5, 2'd0, 16'h0000, 16'd1, 8'h00), -1, 8'h00},
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 1, 8'h00},   // count reached
            '{mk(OP_QUERY, 8'h00, 2'd3, 16'h1234, 16'd1, 8'h00), 0, 8'h00},   // bad unit
            '{mk(3'd7,     8'hFF, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF), 0, 8'h00}, // bad opcode
            // engine query with zero count, address already reported
            '{mk(OP_QUERY, 8'h00, 2'd0, 16'h1234, 16'd0, 8'h00), 4, CODE_RESET},
            '{mk(OP_QUERY, 8'h00, 2'd1, 16'h0000, 16'd1, 8'h00), 0, 8'h00},   // busy
            '{mk(OP_TICK,  8'h00, 2'd0, 16'h0000, 16'd1, 8'h00), 5, CODE_ENGINE},
            '{mk(OP_QUERY, 8'h00, 2'd0, 16'hABCD, 16'hFFFF, 8'h00), 4, CODE_ENGINE}
        };
        foreach (rows[i])
        begin
            offer(rows[i].it, n);
            n_items++;
            if (rows[i].n_res >= 0 &&
                (n != rows[i].n_res ||
                 (n > 0 && owed[owed.size() - n].tx != rows[i].first_tx)))
                report($sformatf("table row %0d owes %0d results, model gives %0d", i,
                                 rows[i].n_res, n));
        end
        drain();

        // random part, one setting after another
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_MAX_WAIT, 8'(phase_wait[p]));
            write_reg(REG_MAX_RETRIES, 8'(phase_retry[p]));
            for (int k = 0; k < phase_items[p]; )
            begin
                if (burst.size() == 0)
                    plan_burst(burst);
                it = burst.pop_front();
                if (p == 0 && k == 30)
                    hold_req = 1'b1;     // receiver backs off, queue fills
                if (p == 0 && k == 70)
                begin
                    in_valid <= 1'b0;
                    while (owed.size() != 0)
                        @(posedge clk);
                    @(posedge clk);
                end
                offer(it, n);
                // transactions that owe no result count only if they are ticks or bytes
                if (n > 0 || it.op == OP_TICK || it.op == OP_BYTE)
                begin
                    k++;
                    n_items++;
                end
            end
            burst.delete();
            drain();
        end

        $display("covered %0d counted input transactions over 6 wait/retry settings",
                 n_items);
        $display("checked %0d results: %0d samples, %0d completion statuses",
                 checked, n_samples, n_status);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
